// ===== rtl/core/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg: shared definitions for the audio peak envelope store
// Command codes, configuration register indexes, fixed-point constants and
// the control structs passed between the sequencer, divider and bucket memory.
// ----------------------------------------------------------------------------
package aps_pkg;

  // Command codes carried by an input word.
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPB   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 4'd1;

  localparam int SPB_W   = 16;
  localparam int CHANS_W = 3;
  localparam logic [SPB_W-1:0]   SPB_RESET   = 16'd256;
  localparam logic [CHANS_W-1:0] CHANS_RESET = 3'd2;

  // Sample ports on the frame interface.
  localparam int IN_CHANNELS = 4;
  localparam int CH_W        = 2;

  // Range bounds and the Q1.15 answer.
  localparam int RANGE_W   = 32;
  localparam int LOUD_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam logic [LOUD_W-1:0] LOUD_ONE = 16'h8000;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/core/audio_peak_envelope_store.sv =====
// A frame word occupies the block while its channels are folded and its bucket is updated;
// the shared comparator takes one channel per cycle.
// A range query runs up to three divisions and a scan over the buckets in range;
// the divider yields one quotient bit per cycle while it is busy.
// One word is in flight at a time; a finished answer waits in the output register.
// Reset is synchronous and active low; the bucket memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// audio_peak_envelope_store: per-bucket peak store with range loudness query
// Folds audio frames into peak buckets, tracks the clip peak and answers
// normalized Q1.15 range peaks, all through one comparator and one divider.
// ----------------------------------------------------------------------------
module audio_peak_envelope_store #(
  parameter int NUM_BUCKETS  = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [aps_pkg::CMD_W-1:0]        in_command,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_0,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_1,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_2,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_3,
  input  logic signed [aps_pkg::RANGE_W-1:0] in_range_start,
  input  logic signed [aps_pkg::RANGE_W-1:0] in_range_end,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aps_pkg::LOUD_W-1:0]       out_loudness,
  output logic                             out_frames_lost
);
  import aps_pkg::*;

  // Bucket index and fill count widths.
  localparam int IDX_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
  // Channels actually present on the interface.
  localparam int CH_LIM = (MAX_CHANNELS < IN_CHANNELS) ? MAX_CHANNELS : IN_CHANNELS;
  // A sample magnitude of the most negative code needs the full sample width unsigned.
  localparam int MAG_W  = SAMPLE_BITS;
  // The divider must hold |range_end - 1| (33 bits) and a peak shifted up by the
  // fraction bits; the divisor holds either the bucket size or the clip peak.
  localparam int DIV_DW = (MAG_W + FRAC_BITS > RANGE_W + 1) ? MAG_W + FRAC_BITS : RANGE_W + 1;
  localparam int DIV_VW = (MAG_W > SPB_W) ? MAG_W : SPB_W;

  // Sequencer. Frame path: CHAN folds channels, FRD opens or reads the current
  // bucket, FCMP updates it, FOVR updates the clip peak and bucket fill.
  // Query path: one or two divisions turn frame indices into bucket indices, QCHK
  // decides whether the range is empty, QSCAN walks the buckets, and a third
  // division normalizes the range peak against the clip peak.
  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CHAN    = 14'b00000000000010,
    S_FRD     = 14'b00000000000100,
    S_FCMP    = 14'b00000000001000,
    S_FOVR    = 14'b00000000010000,
    S_QL_GO   = 14'b00000000100000,
    S_QL_WAIT = 14'b00000001000000,
    S_QF_GO   = 14'b00000010000000,
    S_QF_WAIT = 14'b00000100000000,
    S_QCHK    = 14'b00001000000000,
    S_QSCAN   = 14'b00010000000000,
    S_QN_GO   = 14'b00100000000000,
    S_QN_WAIT = 14'b01000000000000,
    S_QFIN    = 14'b10000000000000
  } state_t;

  state_t               state_r, state_nxt;

  // Configuration registers.
  logic [SPB_W-1:0]     spb_r, spb_nxt;
  logic [CHANS_W-1:0]   chans_r, chans_nxt;

  // Clip state.
  logic [SPB_W-1:0]     fib_r, fib_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [MAG_W-1:0]     overall_r, overall_nxt;
  logic                 overflow_r, overflow_nxt;

  // Per-word working registers.
  logic [SAMPLE_BITS-1:0] samp_r [IN_CHANNELS];
  logic [SAMPLE_BITS-1:0] samp_nxt [IN_CHANNELS];
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [MAG_W-1:0]     run_max_r, run_max_nxt;
  logic [RANGE_W-1:0]   from_r, from_nxt;
  logic [RANGE_W:0]     tm1_r, tm1_nxt;
  logic [IDX_W-1:0]     last_idx_r, last_idx_nxt;
  logic                 last_empty_r, last_empty_nxt;
  logic [IDX_W-1:0]     first_idx_r, first_idx_nxt;
  logic                 first_ge_r, first_ge_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [LOUD_W-1:0]    res_r, res_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [LOUD_W-1:0]    out_loud_r, out_loud_nxt;
  logic                 out_lost_r, out_lost_nxt;

  // Derived values.
  logic [SPB_W-1:0]     per_eff;
  logic [CHANS_W-1:0]   nch;
  logic [CHANS_W-1:0]   last_ch;
  logic [SPB_W:0]       fib_inc;
  logic [CNT_W-1:0]     filled_m1;
  logic [RANGE_W:0]     tm1_abs;
  logic                 in_fire;

  // Shared comparator.
  logic [MAG_W-1:0]     cmp_a, cmp_b;
  logic                 cmp_gt;

  // Divider connection.
  logic                 div_start;
  logic [DIV_DW-1:0]    div_dividend;
  logic [DIV_VW-1:0]    div_divisor;
  div_sts_t             div_sts;
  logic [DIV_DW-1:0]    div_q;

  // Memory connection.
  mem_ctl_t             mem_ctl;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  logic [MAG_W-1:0]     mem_rdata;

  // Magnitude of a two's complement sample; the most negative code maps to
  // the full-scale value, which still fits the unsigned width.
  function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_BITS-1:0] s);
    logic [MAG_W-1:0] neg;
    neg    = ~s + 1'b1;
    mag_of = s[SAMPLE_BITS-1] ? neg : s;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid       = out_valid_r;
  assign out_loudness    = out_loud_r;
  assign out_frames_lost = out_lost_r;

  // A bucket size of zero behaves as one frame per bucket.
  assign per_eff   = (spb_r == '0) ? SPB_W'(1) : spb_r;
  assign fib_inc   = {1'b0, fib_r} + 1'b1;
  assign filled_m1 = filled_r - 1'b1;
  assign tm1_abs   = tm1_r[RANGE_W] ? (~tm1_r + 1'b1) : tm1_r;
  assign last_ch   = nch - 1'b1;

  // Active channel count, clamped to at least one and at most the ports present.
  always_comb begin
    if (chans_r == '0) begin
      nch = CHANS_W'(1);
    end else if (chans_r > CHANS_W'(CH_LIM)) begin
      nch = CHANS_W'(CH_LIM);
    end else begin
      nch = chans_r;
    end
  end

  // Operand selection for the one magnitude comparator.
  always_comb begin
    unique case (state_r)
      S_CHAN: begin
        cmp_a = mag_of(samp_r[ch_r]);
        cmp_b = run_max_r;
      end
      S_FCMP: begin
        cmp_a = run_max_r;
        cmp_b = mem_rdata;
      end
      S_QSCAN: begin
        cmp_a = mem_rdata;
        cmp_b = run_max_r;
      end
      default: begin
        cmp_a = run_max_r;
        cmp_b = overall_r;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);

  // Divider operands. Bucket indices come from the bucket size; the final
  // division scales the range peak by 2^15 against the clip peak.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_DW'(tm1_abs);
    div_divisor  = DIV_VW'(per_eff);
    unique case (state_r)
      S_QL_GO: begin
        div_start = 1'b1;
      end
      S_QF_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'(from_r);
      end
      S_QN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_DW'({run_max_r, {FRAC_BITS{1'b0}}});
        div_divisor  = DIV_VW'(overall_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Main sequencer.
  always_comb begin
    state_nxt      = state_r;
    spb_nxt        = spb_r;
    chans_nxt      = chans_r;
    fib_nxt        = fib_r;
    filled_nxt     = filled_r;
    overall_nxt    = overall_r;
    overflow_nxt   = overflow_r;
    samp_nxt       = samp_r;
    ch_nxt         = ch_r;
    run_max_nxt    = run_max_r;
    from_nxt       = from_r;
    tm1_nxt        = tm1_r;
    last_idx_nxt   = last_idx_r;
    last_empty_nxt = last_empty_r;
    first_idx_nxt  = first_idx_r;
    first_ge_nxt   = first_ge_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_loud_nxt   = out_loud_r;
    out_lost_nxt   = out_lost_r;
    mem_ctl        = '0;
    mem_waddr      = filled_r[IDX_W-1:0];
    mem_raddr      = filled_m1[IDX_W-1:0];

    // Configuration is only to be written while the block is quiet; the block does not enforce this.
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SPB) begin
        spb_nxt = cfg_data[SPB_W-1:0];
      end else if (cfg_index == CFG_CHANS) begin
        chans_nxt = cfg_data[CHANS_W-1:0];
      end
    end

    // The result register drains independently of the sequencer.
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command == CMD_CLEAR) begin
            fib_nxt      = '0;
            filled_nxt   = '0;
            overall_nxt  = '0;
            overflow_nxt = 1'b0;
          end else if (in_command == CMD_FRAME) begin
            samp_nxt[0] = in_sample_0;
            samp_nxt[1] = in_sample_1;
            samp_nxt[2] = in_sample_2;
            samp_nxt[3] = in_sample_3;
            ch_nxt      = '0;
            run_max_nxt = '0;
            state_nxt   = S_CHAN;
          end else if (in_command == CMD_QUERY) begin
            from_nxt = in_range_start;
            tm1_nxt  = {in_range_end[RANGE_W-1], in_range_end} - 1'b1;
            // An empty store or a silent clip answers zero at once.
            if (filled_r == '0 || overall_r == '0) begin
              res_nxt   = '0;
              state_nxt = S_QFIN;
            end else begin
              state_nxt = S_QL_GO;
            end
          end
        end
      end

      S_CHAN: begin
        if (cmp_gt) begin
          run_max_nxt = cmp_a;
        end
        if ({1'b0, ch_r} == last_ch) begin
          state_nxt = S_FRD;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end

      S_FRD: begin
        if (fib_r == '0) begin
          if (filled_r >= CNT_W'(NUM_BUCKETS)) begin
            // Store is full: the frame is dropped and the loss is recorded.
            overflow_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            mem_ctl.wr_en = 1'b1;
            filled_nxt    = filled_r + 1'b1;
            state_nxt     = S_FOVR;
          end
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = S_FCMP;
        end
      end

      S_FCMP: begin
        mem_waddr = filled_m1[IDX_W-1:0];
        if (cmp_gt) begin
          mem_ctl.wr_en = 1'b1;
        end
        state_nxt = S_FOVR;
      end

      S_FOVR: begin
        if (cmp_gt) begin
          overall_nxt = run_max_r;
        end
        if (fib_inc >= {1'b0, per_eff}) begin
          fib_nxt = '0;
        end else begin
          fib_nxt = fib_inc[SPB_W-1:0];
        end
        state_nxt = S_IDLE;
      end

      S_QL_GO: begin
        state_nxt = S_QL_WAIT;
      end

      S_QL_WAIT: begin
        if (div_sts.done) begin
          // The end index truncates toward zero, so a slightly negative end
          // still lands on bucket zero; a larger negative one empties the range.
          if (tm1_r[RANGE_W]) begin
            last_empty_nxt = (div_q != '0);
            last_idx_nxt   = '0;
          end else begin
            last_empty_nxt = 1'b0;
            if (div_q >= DIV_DW'(filled_r)) begin
              last_idx_nxt = filled_m1[IDX_W-1:0];
            end else begin
              last_idx_nxt = div_q[IDX_W-1:0];
            end
          end
          if (from_r[RANGE_W-1]) begin
            // A negative start is clamped to the first bucket.
            first_idx_nxt = '0;
            first_ge_nxt  = 1'b0;
            state_nxt     = S_QCHK;
          end else begin
            state_nxt = S_QF_GO;
          end
        end
      end

      S_QF_GO: begin
        state_nxt = S_QF_WAIT;
      end

      S_QF_WAIT: begin
        if (div_sts.done) begin
          first_ge_nxt  = (div_q >= DIV_DW'(filled_r));
          first_idx_nxt = div_q[IDX_W-1:0];
          state_nxt     = S_QCHK;
        end
      end

      S_QCHK: begin
        if (last_empty_r || first_ge_r || (last_idx_r < first_idx_r)) begin
          res_nxt   = '0;
          state_nxt = S_QFIN;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = first_idx_r;
          idx_nxt       = first_idx_r;
          run_max_nxt   = '0;
          state_nxt     = S_QSCAN;
        end
      end

      S_QSCAN: begin
        // Read data here belongs to idx_r; the next address is issued alongside.
        if (cmp_gt) begin
          run_max_nxt = cmp_a;
        end
        if (idx_r == last_idx_r) begin
          state_nxt = S_QN_GO;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = idx_r + 1'b1;
          idx_nxt       = idx_r + 1'b1;
        end
      end

      S_QN_GO: begin
        state_nxt = S_QN_WAIT;
      end

      S_QN_WAIT: begin
        if (div_sts.done) begin
          if (div_q > DIV_DW'(LOUD_ONE)) begin
            res_nxt = LOUD_ONE;
          end else begin
            res_nxt = div_q[LOUD_W-1:0];
          end
          state_nxt = S_QFIN;
        end
      end

      S_QFIN: begin
        // Wait for the output register to free up before posting the answer.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_loud_nxt  = res_r;
          out_lost_nxt  = overflow_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spb_r       <= SPB_RESET;
      chans_r     <= CHANS_RESET;
      fib_r       <= '0;
      filled_r    <= '0;
      overall_r   <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spb_r       <= spb_nxt;
      chans_r     <= chans_nxt;
      fib_r       <= fib_nxt;
      filled_r    <= filled_nxt;
      overall_r   <= overall_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    samp_r       <= samp_nxt;
    ch_r         <= ch_nxt;
    run_max_r    <= run_max_nxt;
    from_r       <= from_nxt;
    tm1_r        <= tm1_nxt;
    last_idx_r   <= last_idx_nxt;
    last_empty_r <= last_empty_nxt;
    first_idx_r  <= first_idx_nxt;
    first_ge_r   <= first_ge_nxt;
    idx_r        <= idx_nxt;
    res_r        <= res_nxt;
    out_loud_r   <= out_loud_nxt;
    out_lost_r   <= out_lost_nxt;
  end

  aps_div #(
    .DW (DIV_DW),
    .VW (DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  aps_mem #(
    .DEPTH  (NUM_BUCKETS),
    .ADDR_W (IDX_W),
    .DATA_W (MAG_W)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .wr_addr   (mem_waddr),
    .wr_data   (run_max_r),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // The fill count never runs past the store.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(NUM_BUCKETS))
    else $error("bucket fill count exceeds the store depth");

  // A partly filled bucket always has an opened bucket behind it.
  a_open_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    (fib_r != '0) |-> (filled_r != '0))
    else $error("frames counted in a bucket that was never opened");

  // No bucket peak can exceed the clip peak, so the quotient stays at or below one.
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QN_GO) |-> (run_max_r <= overall_r))
    else $error("range peak above clip peak at normalization");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_QL_WAIT || state_r == S_QF_WAIT ||
                      state_r == S_QN_WAIT))
    else $error("divider finished outside a wait state");

  // A new division never starts on top of one in progress.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/core/aps_mem.sv =====
// ----------------------------------------------------------------------------
// aps_mem: bucket peak memory
// Simple dual-port storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aps_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic                clk,
  input  aps_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [DATA_W-1:0]   rd_data_r
);
  import aps_pkg::*;

  logic [DATA_W-1:0] store_r [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

endmodule

// ===== rtl/core/aps_div.sv =====
// ----------------------------------------------------------------------------
// aps_div: shared restoring divider
// Produces one quotient bit per cycle; operands are captured on start.
// ----------------------------------------------------------------------------
module aps_div #(
  parameter int DW = 33,
  parameter int VW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [VW-1:0]     divisor,
  output aps_pkg::div_sts_t sts,
  output logic [DW-1:0]     quotient
);
  import aps_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // A clear top bit of the trial difference means the divisor fits.
      quo_nxt = {quo_r[DW-2:0], ~rem_sub[VW]};
      rem_nxt = rem_sub[VW] ? rem_sh[VW-1:0] : rem_sub[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule
